FILE: rtl/core/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SIP_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("sip assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SIP_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("sip assertion failed");

`endif

FILE: rtl/core/sip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sip_pkg
// shared types for the segment intersection pipeline
// ----------------------------------------------------------------------------
package sip_pkg;

	// per-beat control that travels beside the numeric pipeline
	typedef struct packed {
		logic valid;
		logic hit;
		logic degen;
	} sip_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/segment_intersection_point.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_intersection_point
// two-dimensional segment crossing test and crossing point, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall carry one segment pair per beat,
//   end points p1,p2 and q1,q2 as signed fixed point with 4 fraction bits
//   output channel: out_valid / out_stall carry hit, degenerate and the
//   crossing point; point and degenerate are zero when there is no hit
//   a pair that touches counts as a hit; a hit with a zero denominator
//   (parallel, collinear or a point segment) is degenerate with a zero point
//   the pipe has four front stages, two divider setup stages, one stage per
//   quotient bit (COORD_WIDTH + 1) and a saturating output register
//   throughput is one beat per cycle unless out_stall holds a valid result
//   reset clears all valid bits; payload registers are not reset
//   while out_stall holds a valid result the whole pipe freezes and
//   in_stall rises; nothing is dropped or repeated
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_intersection_point import sip_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] p1_x,
	input  logic signed [COORD_WIDTH-1:0] p1_y,
	input  logic signed [COORD_WIDTH-1:0] p2_x,
	input  logic signed [COORD_WIDTH-1:0] p2_y,
	input  logic signed [COORD_WIDTH-1:0] q1_x,
	input  logic signed [COORD_WIDTH-1:0] q1_y,
	input  logic signed [COORD_WIDTH-1:0] q2_x,
	input  logic signed [COORD_WIDTH-1:0] q2_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic                          degenerate,
	output logic signed [COORD_WIDTH-1:0] cross_x,
	output logic signed [COORD_WIDTH-1:0] cross_y
);

	localparam int W   = COORD_WIDTH;
	localparam int NW  = 3 * W + 5;   // numerator width
	localparam int DDW = 2 * W + 3;   // denominator width
	localparam int DL  = W + 4;       // divider latency

	// pipe advances unless a finished beat is held at the output
	logic en;

	sip_ctl_t              geo_ctl;
	logic signed [NW-1:0]  num_x, num_y;
	logic signed [DDW-1:0] den;
	logic signed [W-1:0]   quo_x, quo_y;

	// control line matched to the divider depth
	sip_ctl_t ctl_s [DL];

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	sip_geom #(.W(W)) u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.p1_x     (p1_x),
		.p1_y     (p1_y),
		.p2_x     (p2_x),
		.p2_y     (p2_y),
		.q1_x     (q1_x),
		.q1_y     (q1_y),
		.q2_x     (q2_x),
		.q2_y     (q2_y),
		.ctl      (geo_ctl),
		.num_x    (num_x),
		.num_y    (num_y),
		.den      (den)
	);

	// x and y quotients share the denominator
	sip_div #(.W(W), .NW(NW), .DDW(DDW)) u_div_x (
		.clk (clk),
		.en  (en),
		.num (num_x),
		.den (den),
		.quo (quo_x)
	);

	sip_div #(.W(W), .NW(NW), .DDW(DDW)) u_div_y (
		.clk (clk),
		.en  (en),
		.num (num_y),
		.den (den),
		.quo (quo_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DL; i++)
				ctl_s[i] <= '0;
		end else if (en) begin
			ctl_s[0] <= geo_ctl;
			for (int i = 1; i < DL; i++)
				ctl_s[i] <= ctl_s[i-1];
		end
	end

	// the point is only meaningful on a hit with a nonzero denominator
	assign out_valid  = ctl_s[DL-1].valid;
	assign hit        = ctl_s[DL-1].hit;
	assign degenerate = ctl_s[DL-1].degen;
	assign cross_x    = (hit && !degenerate) ? quo_x : '0;
	assign cross_y    = (hit && !degenerate) ? quo_y : '0;

	// degenerate is a refinement of hit
	`SIP_ASSERT_NOW(a_degen_hit, clk, arst_n, out_valid && degenerate, hit)
	// a miss or degenerate result carries a zero point
	`SIP_ASSERT_NOW(a_zero_pt, clk, arst_n, out_valid && (!hit || degenerate),
		(cross_x == '0) && (cross_y == '0))
	// a held result freezes the control line
	`SIP_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(hit) && $stable(degenerate))

endmodule
`default_nettype wire

FILE: rtl/core/sip_geom.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sip_geom
// four-stage front end: differences, cross products, straddle test and
// the two numerators and shared denominator of the crossing point
// ----------------------------------------------------------------------------
module sip_geom import sip_pkg::*; #(
	parameter int W = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic signed [W-1:0]    p1_x,
	input  logic signed [W-1:0]    p1_y,
	input  logic signed [W-1:0]    p2_x,
	input  logic signed [W-1:0]    p2_y,
	input  logic signed [W-1:0]    q1_x,
	input  logic signed [W-1:0]    q1_y,
	input  logic signed [W-1:0]    q2_x,
	input  logic signed [W-1:0]    q2_y,
	output sip_ctl_t               ctl,
	output logic signed [3*W+4:0]  num_x,
	output logic signed [3*W+4:0]  num_y,
	output logic signed [2*W+2:0]  den
);

	localparam int DW  = W + 1;
	localparam int PW  = 2 * DW;
	localparam int TW  = PW + DW;
	localparam int NW  = 3 * W + 5;
	localparam int DDW = PW + 1;

	// stage 1
	logic                 v_s1, box_s1;
	logic signed [DW-1:0] a_s1, b_s1, c_s1, d_s1;
	logic signed [DW-1:0] pq1y_s1, pq1x_s1, p2q1y_s1, p2q1x_s1;
	logic signed [DW-1:0] qp1y_s1, qp1x_s1, q2p1y_s1, q2p1x_s1, q2p2x_s1;
	logic signed [W-1:0]  q1x_s1, p1x_s1, p2y_s1, q2y_s1;
	logic signed [W-1:0]  pminx, pmaxx, pminy, pmaxy, qminx, qmaxx, qminy, qmaxy;

	// stage 2
	logic                 v_s2, box_s2;
	logic signed [PW-1:0] mc1_s2, md1_s2, mc2_s2, md2_s2;
	logic signed [PW-1:0] ma1_s2, mb1_s2, ma2_s2, mb2_s2;
	logic signed [PW-1:0] ad_s2, bc_s2, ac_s2, bd_s2;
	logic signed [DW-1:0] pq1y_s2, q2p2x_s2;
	logic signed [W-1:0]  q1x_s2, p1x_s2, p2y_s2, q2y_s2;

	// stage 3
	logic                  v_s3, box_s3;
	logic signed [PW:0]    d1_s3, d2_s3, e1_s3, e2_s3;
	logic signed [DDW-1:0] den_s3;
	logic signed [TW-1:0]  t1_s3, t2_s3, t3_s3, t4_s3, t5_s3, t6_s3;

	// stage 4
	logic v_s4, hit_s4, degen_s4;

	logic st_d, st_e, hit_c;

	assign pminx = (p1_x < p2_x) ? p1_x : p2_x;
	assign pmaxx = (p1_x < p2_x) ? p2_x : p1_x;
	assign pminy = (p1_y < p2_y) ? p1_y : p2_y;
	assign pmaxy = (p1_y < p2_y) ? p2_y : p1_y;
	assign qminx = (q1_x < q2_x) ? q1_x : q2_x;
	assign qmaxx = (q1_x < q2_x) ? q2_x : q1_x;
	assign qminy = (q1_y < q2_y) ? q1_y : q2_y;
	assign qmaxy = (q1_y < q2_y) ? q2_y : q1_y;

	// touching counts as crossing: a zero term or opposite signs pass
	assign st_d  = (d1_s3 == '0) || (d2_s3 == '0) || (d1_s3[PW] != d2_s3[PW]);
	assign st_e  = (e1_s3 == '0) || (e2_s3 == '0) || (e1_s3[PW] != e2_s3[PW]);
	assign hit_c = box_s3 && st_d && st_e;

	assign ctl = '{valid: v_s4, hit: hit_s4, degen: degen_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			box_s1   <= (pminx <= qmaxx) && (qminx <= pmaxx) &&
			            (pminy <= qmaxy) && (qminy <= pmaxy);
			a_s1     <= DW'(p2_x) - DW'(p1_x);
			b_s1     <= DW'(p2_y) - DW'(p1_y);
			c_s1     <= DW'(q2_x) - DW'(q1_x);
			d_s1     <= DW'(q2_y) - DW'(q1_y);
			pq1y_s1  <= DW'(p1_y) - DW'(q1_y);
			pq1x_s1  <= DW'(p1_x) - DW'(q1_x);
			p2q1y_s1 <= DW'(p2_y) - DW'(q1_y);
			p2q1x_s1 <= DW'(p2_x) - DW'(q1_x);
			qp1y_s1  <= DW'(q1_y) - DW'(p1_y);
			qp1x_s1  <= DW'(q1_x) - DW'(p1_x);
			q2p1y_s1 <= DW'(q2_y) - DW'(p1_y);
			q2p1x_s1 <= DW'(q2_x) - DW'(p1_x);
			q2p2x_s1 <= DW'(q2_x) - DW'(p2_x);
			q1x_s1   <= q1_x;
			p1x_s1   <= p1_x;
			p2y_s1   <= p2_y;
			q2y_s1   <= q2_y;

			box_s2   <= box_s1;
			mc1_s2   <= PW'(c_s1) * PW'(pq1y_s1);
			md1_s2   <= PW'(d_s1) * PW'(pq1x_s1);
			mc2_s2   <= PW'(c_s1) * PW'(p2q1y_s1);
			md2_s2   <= PW'(d_s1) * PW'(p2q1x_s1);
			ma1_s2   <= PW'(a_s1) * PW'(qp1y_s1);
			mb1_s2   <= PW'(b_s1) * PW'(qp1x_s1);
			ma2_s2   <= PW'(a_s1) * PW'(q2p1y_s1);
			mb2_s2   <= PW'(b_s1) * PW'(q2p1x_s1);
			ad_s2    <= PW'(a_s1) * PW'(d_s1);
			bc_s2    <= PW'(b_s1) * PW'(c_s1);
			ac_s2    <= PW'(a_s1) * PW'(c_s1);
			bd_s2    <= PW'(b_s1) * PW'(d_s1);
			pq1y_s2  <= pq1y_s1;
			q2p2x_s2 <= q2p2x_s1;
			q1x_s2   <= q1x_s1;
			p1x_s2   <= p1x_s1;
			p2y_s2   <= p2y_s1;
			q2y_s2   <= q2y_s1;

			box_s3   <= box_s2;
			d1_s3    <= (PW+1)'(mc1_s2) - (PW+1)'(md1_s2);
			d2_s3    <= (PW+1)'(mc2_s2) - (PW+1)'(md2_s2);
			e1_s3    <= (PW+1)'(ma1_s2) - (PW+1)'(mb1_s2);
			e2_s3    <= (PW+1)'(ma2_s2) - (PW+1)'(mb2_s2);
			den_s3   <= DDW'(ad_s2) - DDW'(bc_s2);
			t1_s3    <= TW'(ac_s2) * TW'(pq1y_s2);
			t2_s3    <= TW'(ad_s2) * TW'(q1x_s2);
			t3_s3    <= TW'(bc_s2) * TW'(p1x_s2);
			t4_s3    <= TW'(bd_s2) * TW'(q2p2x_s2);
			t5_s3    <= TW'(ad_s2) * TW'(p2y_s2);
			t6_s3    <= TW'(bc_s2) * TW'(q2y_s2);

			hit_s4   <= hit_c;
			degen_s4 <= hit_c && (den_s3 == '0);
			num_x    <= NW'(t1_s3) + NW'(t2_s3) - NW'(t3_s3);
			num_y    <= NW'(t4_s3) + NW'(t5_s3) - NW'(t6_s3);
			den      <= den_s3;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/sip_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sip_div
// pipelined restoring divider, one quotient bit per stage, quotient
// truncated toward zero and saturated to the coordinate range
// ----------------------------------------------------------------------------
module sip_div import sip_pkg::*; #(
	parameter int W   = 16,
	parameter int NW  = 53,
	parameter int DDW = 35
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [NW-1:0]  num,
	input  logic signed [DDW-1:0] den,
	output logic signed [W-1:0]   quo
);

	localparam int Q   = W + 1;
	localparam int CW  = NW + 1;
	localparam int LIM = 2 ** (W - 1);

	logic [NW-1:0]  nmag_a;
	logic [DDW-1:0] dmag_a;
	logic           neg_a;

	logic [NW-1:0]  rem_s  [Q+1];
	logic [Q-1:0]   q_s    [Q+1];
	logic [DDW-1:0] dmag_s [Q+1];
	logic           neg_s  [Q+1];
	logic           ovf_s  [Q+1];

	logic [Q-1:0]   qmag;
	logic           neg_f, ovf_f;

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_a    <= num[NW-1] ? NW'(-num) : NW'(num);
			dmag_a    <= den[DDW-1] ? DDW'(-den) : DDW'(den);
			neg_a     <= num[NW-1] ^ den[DDW-1];
			// quotient does not fit in Q bits
			ovf_s[0]  <= {1'b0, nmag_a} >= CW'({dmag_a, {Q{1'b0}}});
			rem_s[0]  <= nmag_a;
			q_s[0]    <= '0;
			dmag_s[0] <= dmag_a;
			neg_s[0]  <= neg_a;
		end
	end

	for (genvar i = 0; i < Q; i++) begin : g_step
		localparam int K = Q - 1 - i;
		logic [CW-1:0] trial;
		assign trial = {1'b0, rem_s[i]} - (CW'(dmag_s[i]) << K);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= trial[CW-1] ? rem_s[i] : trial[NW-1:0];
				q_s[i+1]    <= q_s[i] | (Q'(!trial[CW-1]) << K);
				dmag_s[i+1] <= dmag_s[i];
				neg_s[i+1]  <= neg_s[i];
				ovf_s[i+1]  <= ovf_s[i];
			end
		end
	end

	assign qmag  = q_s[Q];
	assign neg_f = neg_s[Q];
	assign ovf_f = ovf_s[Q];

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_f) begin
				if (ovf_f || (qmag > Q'(LIM)))
					quo <= W'(-LIM);
				else
					quo <= W'(-qmag);
			end else begin
				if (ovf_f || (qmag > Q'(LIM - 1)))
					quo <= W'(LIM - 1);
				else
					quo <= W'(qmag);
			end
		end
	end

endmodule
`default_nettype wire
